### design/converter_mode_controller_macros.svh
// Assertion macros used by the checker file of the converter mode controller.
`ifndef CONVERTER_MODE_CONTROLLER_MACROS_SVH
`define CONVERTER_MODE_CONTROLLER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the next clock edge, outside reset.
`define CMC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/cmc_pkg.sv
`default_nettype none

package cmc_pkg;

    // Mode codes as shown on the result stream.
    typedef enum logic [2:0] {
        MODE_INIT      = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_WAIT_BUS  = 3'd2,
        MODE_DISCHARGE = 3'd3,
        MODE_CHARGE    = 3'd4,
        MODE_STOP      = 3'd5,
        MODE_FAULT     = 3'd6
    } t_mode;

    // Ticks allowed in wait-bus after reset (5 s at a 1 ms tick).
    localparam logic [15:0] BUS_WAIT_LIMIT_RESET = 16'd5000;

    // Flags of one tick.
    typedef struct packed {
        logic aux_supply_on;
        logic battery_discharging;
        logic external_fault;
        logic charge_command;
        logic inverter_command;
        logic front_stage_direction;
        logic front_stage_discharging;
        logic bus_voltage_ok;
        logic read_ups_flag;
    } t_tick;

    // Result of one tick.
    typedef struct packed {
        t_mode mode_state;
        logic  charge_enable;
        logic  discharge_enable;
        logic  ups_flag_value;
        logic  bus_timeout_fault;
    } t_result;

endpackage

`default_nettype wire

### design/cmc_fsm.sv
`default_nettype none

// Mode machine, wait-bus counter, latches and the wait limit register.
module cmc_fsm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire cmc_pkg::t_tick  i_tick,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_limit,
    output cmc_pkg::t_result     o_result
);

    cmc_pkg::t_mode r_mode;
    cmc_pkg::t_mode n_mode;
    logic [15:0]    r_wait;
    logic [15:0]    n_wait;
    logic           r_ups;
    logic           n_ups;
    logic           r_timeout;
    logic           n_timeout;
    logic [15:0]    r_limit;
    logic [15:0]    wait_inc;
    logic           fault_old;

    // Saturating increment of the wait-bus count.
    assign wait_inc  = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;
    assign fault_old = i_tick.external_fault | r_timeout;

    // Next state for the tick being accepted.
    always_comb begin
        n_mode    = r_mode;
        n_wait    = r_wait;
        n_ups     = r_ups & ~i_tick.read_ups_flag;
        n_timeout = r_timeout;
        case (r_mode)
            cmc_pkg::MODE_INIT: begin
                if (i_tick.aux_supply_on && i_tick.battery_discharging) begin
                    n_mode = cmc_pkg::MODE_IDLE;
                end
            end
            cmc_pkg::MODE_IDLE: begin
                // A present fault keeps the machine idle.
                if (!fault_old) begin
                    if (i_tick.charge_command && !i_tick.front_stage_direction) begin
                        n_mode = cmc_pkg::MODE_WAIT_BUS;
                    end else if (i_tick.inverter_command && i_tick.front_stage_direction) begin
                        if (i_tick.front_stage_discharging) begin
                            n_ups = 1'b1;
                        end
                        n_mode = cmc_pkg::MODE_DISCHARGE;
                    end
                end
            end
            cmc_pkg::MODE_WAIT_BUS: begin
                n_wait = wait_inc;
                if (i_tick.bus_voltage_ok) begin
                    n_mode = cmc_pkg::MODE_CHARGE;
                end else if (i_tick.front_stage_direction && i_tick.inverter_command) begin
                    n_mode = cmc_pkg::MODE_DISCHARGE;
                end
                if (i_tick.front_stage_direction && !i_tick.inverter_command) begin
                    n_mode = cmc_pkg::MODE_STOP;
                end
                // A timeout raised now already counts as an active fault.
                if (wait_inc > r_limit) begin
                    n_timeout = 1'b1;
                end
                if (i_tick.external_fault || n_timeout) begin
                    n_mode = cmc_pkg::MODE_FAULT;
                end
            end
            cmc_pkg::MODE_DISCHARGE: begin
                if (!i_tick.front_stage_direction) begin
                    n_mode = i_tick.charge_command ? cmc_pkg::MODE_WAIT_BUS
                                                   : cmc_pkg::MODE_STOP;
                end else if (!i_tick.inverter_command) begin
                    n_mode = cmc_pkg::MODE_STOP;
                end
                if (fault_old) begin
                    n_mode = cmc_pkg::MODE_FAULT;
                end
            end
            cmc_pkg::MODE_CHARGE: begin
                if (i_tick.front_stage_direction) begin
                    if (i_tick.front_stage_discharging) begin
                        n_ups  = 1'b1;
                        n_mode = cmc_pkg::MODE_DISCHARGE;
                    end else begin
                        n_mode = cmc_pkg::MODE_STOP;
                    end
                end else if (!i_tick.charge_command) begin
                    n_mode = cmc_pkg::MODE_STOP;
                end
                if (fault_old) begin
                    n_mode = cmc_pkg::MODE_FAULT;
                end
            end
            cmc_pkg::MODE_STOP: begin
                n_mode = cmc_pkg::MODE_IDLE;
            end
            default: begin
                // Fault is terminal; the unused code behaves the same.
                n_mode = cmc_pkg::MODE_FAULT;
            end
        endcase
        // Entering wait-bus restarts the count.
        if (n_mode != r_mode && n_mode == cmc_pkg::MODE_WAIT_BUS) begin
            n_wait = 16'd0;
        end
    end

    // Result fields of the tick.
    always_comb begin
        o_result.mode_state        = n_mode;
        o_result.charge_enable     = (n_mode == cmc_pkg::MODE_CHARGE);
        o_result.discharge_enable  = (n_mode == cmc_pkg::MODE_DISCHARGE);
        o_result.ups_flag_value    = i_tick.read_ups_flag & r_ups;
        o_result.bus_timeout_fault = n_timeout;
    end

    // State update on each accepted tick; limit update on each config write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cmc_pkg::MODE_INIT;
            r_wait    <= 16'd0;
            r_ups     <= 1'b0;
            r_timeout <= 1'b0;
            r_limit   <= cmc_pkg::BUS_WAIT_LIMIT_RESET;
        end else begin
            if (i_accept) begin
                r_mode    <= n_mode;
                r_wait    <= n_wait;
                r_ups     <= n_ups;
                r_timeout <= n_timeout;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
        end
    end

endmodule

`default_nettype wire

### design/cmc_out_reg.sv
`default_nettype none

// Result register that holds one finished result until it is taken.
module cmc_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire cmc_pkg::t_result  i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_free,
    output cmc_pkg::t_result       o_result
);

    logic             r_valid;
    cmc_pkg::t_result r_result;

    // The register can take a new result when empty or being drained.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### design/converter_mode_controller.sv
// Channel     Direction  Width  Content
// s_axis      in         16     one tick of status and command flags
// m_axis      out        8      mode and enables after the tick
// cfg         in         16     bus_wait_limit write
//
// Each tick is decided in the cycle it is accepted; its result appears on
// m_axis on the next cycle. One tick per cycle is accepted as long as the
// result register is empty or is taken in that same cycle.
// A stall on m_axis stops s_axis after one held result; cfg is always ready.
// Reset is synchronous and active low.
`default_nettype none

module converter_mode_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] aux_supply_on, [1] battery_discharging, [2] external_fault,
    // [3] charge_command, [4] inverter_command, [5] front_stage_direction,
    // [6] front_stage_discharging, [7] bus_voltage_ok, [8] read_ups_flag,
    // [15:9] zero
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] mode_state, [3] charge_enable, [4] discharge_enable,
    // [5] ups_flag_value, [6] bus_timeout_fault, [7] zero
    output logic [7:0]       m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    cmc_pkg::t_tick   tick;
    cmc_pkg::t_result fsm_result;
    cmc_pkg::t_result out_result;
    logic             accept;
    logic             out_free;

    // Unpack the tick flags.
    always_comb begin
        tick.aux_supply_on           = s_axis_tdata[0];
        tick.battery_discharging     = s_axis_tdata[1];
        tick.external_fault          = s_axis_tdata[2];
        tick.charge_command          = s_axis_tdata[3];
        tick.inverter_command        = s_axis_tdata[4];
        tick.front_stage_direction   = s_axis_tdata[5];
        tick.front_stage_discharging = s_axis_tdata[6];
        tick.bus_voltage_ok          = s_axis_tdata[7];
        tick.read_ups_flag           = s_axis_tdata[8];
    end

    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && out_free;
    assign o_cfg_ready   = 1'b1;

    cmc_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_tick      (tick),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_limit (i_cfg_data),
        .o_result    (fsm_result)
    );

    cmc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (fsm_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {1'b0,
                           out_result.bus_timeout_fault,
                           out_result.ups_flag_value,
                           out_result.discharge_enable,
                           out_result.charge_enable,
                           out_result.mode_state};

endmodule

`default_nettype wire

### design/cmc_checker.sv
`default_nettype none
`include "converter_mode_controller_macros.svh"

// Port-level checks of the converter mode controller.
module cmc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata
);

    logic r_seen_timeout;
    logic r_seen_fault;
    logic out_done;

    assign out_done = m_axis_tvalid && m_axis_tready;

    // Remember whether a delivered result showed the timeout or the fault mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_timeout <= 1'b0;
            r_seen_fault   <= 1'b0;
        end else if (out_done) begin
            if (m_axis_tdata[6]) begin
                r_seen_timeout <= 1'b1;
            end
            if (m_axis_tdata[2:0] == cmc_pkg::MODE_FAULT) begin
                r_seen_fault <= 1'b1;
            end
        end
    end

    `CMC_ASSERT(a_chg_en, !m_axis_tvalid || (m_axis_tdata[3] == (m_axis_tdata[2:0] == cmc_pkg::MODE_CHARGE)), "charge enable does not match mode")
    `CMC_ASSERT(a_dsg_en, !m_axis_tvalid || (m_axis_tdata[4] == (m_axis_tdata[2:0] == cmc_pkg::MODE_DISCHARGE)), "discharge enable does not match mode")
    `CMC_ASSERT(a_timeout_sticky, !(m_axis_tvalid && r_seen_timeout) || m_axis_tdata[6], "bus timeout fault cleared")
    `CMC_ASSERT(a_fault_terminal, !(m_axis_tvalid && r_seen_fault) || (m_axis_tdata[2:0] == cmc_pkg::MODE_FAULT), "left fault mode")
    `CMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind converter_mode_controller cmc_checker u_cmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
